FILE: rtl/core/tnbm_pkg.sv
`timescale 1ns / 1ps
package tnbm_pkg;

  localparam int MaxInputs = 64;
  localparam int IdxW = $clog2(MaxInputs);
  localparam int TanhSize = 256;
  localparam int TanhTblW = 16 * (TanhSize + 1);

  typedef enum logic [2:0] {
    OP_LOAD = 3'd0,
    OP_FWD  = 3'd1,
    OP_OGRAD = 3'd2,
    OP_HGRAD = 3'd3,
    OP_UPD  = 3'd4,
    OP_READ = 3'd5
  } op_t;

  typedef enum logic [1:0] {
    K_ACT  = 2'd0,
    K_GRAD = 2'd1,
    K_UPD  = 2'd2,
    K_READ = 2'd3
  } kind_t;

  localparam logic CFG_LEARN_RATE = 1'b0;
  localparam logic CFG_MOMENTUM   = 1'b1;

  typedef struct packed {
    logic [2:0]         opcode;
    logic [5:0]         index;
    logic signed [23:0] value_a;
    logic signed [23:0] value_b;
    logic               last;
  } in_t;

  typedef struct packed {
    logic [1:0]         kind;
    logic signed [23:0] value;
    logic               saturated;
  } out_t;

  typedef enum logic [3:0] {
    S_IDLE, S_RD, S_FWD_ACC, S_TANH_A, S_TANH_B, S_SQ, S_D,
    S_OG, S_HG_RND, S_HG_MUL, S_U1, S_U2, S_U3, S_U4, S_EMIT
  } state_t;

  // long division, elaboration only
  function automatic logic [63:0] udiv64(input logic [63:0] n, input logic [63:0] d);
    logic [63:0] q, r;
    q = '0;
    r = '0;
    for (int b = 63; b >= 0; b--) begin
      r = {r[62:0], n[b]};
      if (r >= d) begin
        r = r - d;
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  // tanh(4k/TanhSize) in Q0.16, k = 0..TanhSize; e^(8/N) by Taylor series in Q32
  function automatic logic [TanhTblW-1:0] build_tanh_tbl();
    logic [TanhTblW-1:0] tbl;
    logic [63:0] x, term, step, e, frac, num, den;
    tbl = '0;
    x = udiv64(64'd8 << 32, 64'(TanhSize));
    term = 64'd1 << 32;
    step = term;
    e = term;
    for (int k = 1; k <= 16; k++) begin
      term = udiv64((term * x) >> 32, 64'(k));
      step = step + term;
    end
    frac = step - (64'd1 << 32);
    for (int k = 0; k <= TanhSize; k++) begin
      num = (e - (64'd1 << 32)) << 16;
      den = e + (64'd1 << 32);
      tbl[16*k +: 16] = 16'(udiv64(num + (den >> 1), den));
      e = e + (e >> 32) * frac + (((e & 64'hFFFFFFFF) * frac) >> 32);
    end
    return tbl;
  endfunction

  localparam logic [TanhTblW-1:0] TanhTbl = build_tanh_tbl();

  function automatic logic signed [23:0] sat24(input logic signed [63:0] x,
                                               output logic flag);
    flag = 1'b0;
    if (x > 64'sd8388607) begin
      flag = 1'b1;
      return 24'sh7fffff;
    end else if (x < -64'sd8388608) begin
      flag = 1'b1;
      return 24'sh800000;
    end
    return x[23:0];
  endfunction

  function automatic logic signed [63:0] rnd16(input logic signed [63:0] x);
    logic signed [63:0] t;
    t = x + 64'sd32768;
    return t >>> 16;
  endfunction

endpackage

FILE: rtl/core/tanh_neuron_backprop_momentum.sv
`timescale 1ns / 1ps
// Single tanh neuron with backpropagation and momentum weight update. An item
// is taken when start is high and busy low; busy then stays high while one
// shared 32x32 multiplier, stepped by a small sequencer with registered
// weight, delta and input memories, works the item through; unused opcodes
// are dropped without raising busy. A result is shown for exactly one cycle
// with out_valid high, in the first cycle after busy falls, and must be
// captured then: there is no back-pressure.
module tanh_neuron_backprop_momentum (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  tnbm_pkg::in_t        in_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic                 cfg_index,
  input  logic [15:0]          cfg_data,
  output logic                 out_valid,
  output tnbm_pkg::out_t       out_data
);

  logic signed [23:0] weight_mem [tnbm_pkg::MaxInputs];
  logic signed [23:0] input_mem  [tnbm_pkg::MaxInputs];
  logic signed [23:0] delta_mem  [tnbm_pkg::MaxInputs];
  logic [tnbm_pkg::MaxInputs-1:0] delta_vld_r;

  tnbm_pkg::state_t state_r, state_nxt;
  tnbm_pkg::in_t    item_r;
  logic [15:0] lr_r, mom_r;
  logic signed [47:0] acc_r;
  logic signed [23:0] act_r, grad_r;
  logic signed [23:0] w_rd_r, x_rd_r, d_rd_r;
  logic signed [63:0] p_r;         // product register of the shared multiplier
  logic signed [63:0] t_r;         // scratch
  logic signed [23:0] dv_r;        // derivative, or tanh step between points
  logic               flag_r;
  logic               ov_r;
  tnbm_pkg::out_t     od_r;

  logic [tnbm_pkg::IdxW-1:0] idx;
  assign idx = item_r.index[tnbm_pkg::IdxW-1:0];

  // shared multiplier operands
  logic signed [31:0] ma, mb;
  logic signed [63:0] mprod;
  assign mprod = ma * mb;

  logic signed [63:0] amag;
  assign amag = acc_r[47] ? -64'(acc_r) : 64'(acc_r);

  logic [8:0]  ti;
  logic [15:0] tbl_a, tbl_b;
  logic signed [63:0] ty;
  logic signed [23:0] tv;
  logic signed [63:0] asum;
  logic signed [23:0] s1, s2;
  logic        f1, f2;
  logic signed [63:0] accx;

  always_comb begin
    ma = '0;
    mb = '0;
    case (state_r)
      tnbm_pkg::S_FWD_ACC: begin
        ma = 32'(item_r.value_a);
        mb = 32'(w_rd_r);
      end
      tnbm_pkg::S_HG_RND: begin
        ma = 32'(item_r.value_a);
        mb = 32'(item_r.value_b);
      end
      tnbm_pkg::S_TANH_B: begin
        ma = 32'(dv_r);
        mb = 32'(signed'({1'b0, t_r[15:0]}));
      end
      tnbm_pkg::S_SQ: begin
        ma = 32'(act_r);
        mb = 32'(act_r);
      end
      tnbm_pkg::S_OG: begin
        ma = 32'(t_r);
        mb = 32'(dv_r);
      end
      tnbm_pkg::S_HG_MUL: begin
        ma = 32'(t_r);
        mb = 32'(dv_r);
      end
      tnbm_pkg::S_U1: begin
        ma = 32'(signed'({1'b0, lr_r}));
        mb = 32'(x_rd_r);
      end
      tnbm_pkg::S_U2: begin
        ma = 32'(p_r);
        mb = 32'(grad_r);
      end
      tnbm_pkg::S_U3: begin
        ma = 32'(signed'({1'b0, mom_r}));
        mb = 32'(d_rd_r);
      end
      default: ;
    endcase
  end

  always_comb begin
    accx = 64'(acc_r) + mprod;
    asum = accx;
    if (accx > 64'sd140737488355327) begin
      asum = 64'sd140737488355327;
    end else if (accx < -64'sd140737488355328) begin
      asum = -64'sd140737488355328;
    end
    // table index is |acc| >> 26 for the 256 table intervals over [0, 4)
    ti    = {1'b0, amag[33:26]};
    tbl_a = tnbm_pkg::TanhTbl[{ti, 4'b0000} +: 16];
    tbl_b = tnbm_pkg::TanhTbl[{ti + 9'd1, 4'b0000} +: 16];
    ty    = p_r + tnbm_pkg::rnd16(mprod);
    tv    = acc_r[47] ? 24'(-ty) : 24'(ty);
    s1 = tnbm_pkg::sat24(tnbm_pkg::rnd16(64'(acc_r)), f1);
    s2 = tnbm_pkg::sat24(tnbm_pkg::rnd16(p_r), f2);
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      tnbm_pkg::S_IDLE:
        if (start) begin
          case (in_data.opcode)
            tnbm_pkg::OP_LOAD:  state_nxt = tnbm_pkg::S_EMIT;
            tnbm_pkg::OP_FWD, tnbm_pkg::OP_UPD, tnbm_pkg::OP_READ:
              state_nxt = tnbm_pkg::S_RD;
            tnbm_pkg::OP_OGRAD: state_nxt = tnbm_pkg::S_SQ;
            tnbm_pkg::OP_HGRAD: state_nxt = tnbm_pkg::S_HG_RND;
            default:            state_nxt = tnbm_pkg::S_IDLE;
          endcase
        end
      tnbm_pkg::S_RD:
        case (item_r.opcode)
          tnbm_pkg::OP_FWD: state_nxt = tnbm_pkg::S_FWD_ACC;
          tnbm_pkg::OP_UPD: state_nxt = tnbm_pkg::S_U1;
          default:          state_nxt = tnbm_pkg::S_EMIT;
        endcase
      tnbm_pkg::S_FWD_ACC:
        state_nxt = item_r.last ? tnbm_pkg::S_TANH_A : tnbm_pkg::S_IDLE;
      tnbm_pkg::S_TANH_A: state_nxt = tnbm_pkg::S_TANH_B;
      tnbm_pkg::S_TANH_B: state_nxt = tnbm_pkg::S_IDLE;
      tnbm_pkg::S_SQ:     state_nxt = tnbm_pkg::S_D;
      tnbm_pkg::S_D:
        state_nxt = (item_r.opcode == tnbm_pkg::OP_OGRAD) ? tnbm_pkg::S_OG
                                                          : tnbm_pkg::S_HG_MUL;
      tnbm_pkg::S_OG:     state_nxt = tnbm_pkg::S_EMIT;
      tnbm_pkg::S_HG_RND:
        state_nxt = item_r.last ? tnbm_pkg::S_SQ : tnbm_pkg::S_IDLE;
      tnbm_pkg::S_HG_MUL: state_nxt = tnbm_pkg::S_EMIT;
      tnbm_pkg::S_U1:     state_nxt = tnbm_pkg::S_U2;
      tnbm_pkg::S_U2:     state_nxt = tnbm_pkg::S_U3;
      tnbm_pkg::S_U3:     state_nxt = tnbm_pkg::S_U4;
      tnbm_pkg::S_U4:     state_nxt = tnbm_pkg::S_EMIT;
      tnbm_pkg::S_EMIT:   state_nxt = tnbm_pkg::S_IDLE;
      default:            state_nxt = tnbm_pkg::S_IDLE;
    endcase
  end

  assign busy      = (state_r != tnbm_pkg::S_IDLE);
  assign cfg_ready = ~busy;
  assign out_valid = ov_r;
  assign out_data  = od_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= tnbm_pkg::S_IDLE;
      lr_r        <= 16'd9830;
      mom_r       <= 16'd32768;
      acc_r       <= '0;
      act_r       <= '0;
      grad_r      <= '0;
      delta_vld_r <= '0;
      ov_r        <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ov_r    <= 1'b0;
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == tnbm_pkg::CFG_LEARN_RATE) lr_r <= cfg_data;
        else                                       mom_r <= cfg_data;
      end
      case (state_r)
        tnbm_pkg::S_IDLE:
          if (start) begin
            item_r <= in_data;
            flag_r <= 1'b0;
            t_r    <= 64'(in_data.value_a) - 64'(act_r);
          end
        tnbm_pkg::S_RD: begin
          if (item_r.opcode == tnbm_pkg::OP_FWD) input_mem[idx] <= item_r.value_a;
        end
        tnbm_pkg::S_FWD_ACC, tnbm_pkg::S_HG_RND: begin
          acc_r <= asum[47:0];
        end
        tnbm_pkg::S_TANH_A: begin
          // p_r: table point, dv_r: step to the next point, t_r: fraction
          if (amag >= (64'sd4 <<< 32)) begin
            p_r  <= 64'(tnbm_pkg::TanhTbl[16*tnbm_pkg::TanhSize +: 16]);
            dv_r <= '0;
            t_r  <= '0;
          end else begin
            p_r  <= 64'(tbl_a);
            dv_r <= 24'(tbl_b) - 24'(tbl_a);
            t_r  <= 64'(amag[25:10]);
          end
        end
        tnbm_pkg::S_TANH_B: begin
          act_r <= tv;
          acc_r <= '0;
          od_r  <= '{kind: tnbm_pkg::K_ACT, value: tv, saturated: 1'b0};
          ov_r  <= 1'b1;
        end
        tnbm_pkg::S_SQ: begin
          p_r <= mprod;
          if (item_r.opcode == tnbm_pkg::OP_HGRAD) begin
            t_r    <= 64'(s1);
            flag_r <= f1;
          end
        end
        tnbm_pkg::S_D: dv_r <= 24'(64'sd65536 - tnbm_pkg::rnd16(p_r));
        tnbm_pkg::S_OG, tnbm_pkg::S_HG_MUL: begin
          p_r <= mprod;
          acc_r <= (item_r.opcode == tnbm_pkg::OP_HGRAD) ? '0 : acc_r;
        end
        tnbm_pkg::S_U1: p_r <= tnbm_pkg::rnd16(mprod);
        tnbm_pkg::S_U2: t_r <= tnbm_pkg::rnd16(mprod);
        // scaled by 2^16 so that the shared round-and-clamp gives the exact sum
        tnbm_pkg::S_U3: p_r <= (t_r + tnbm_pkg::rnd16(mprod)) <<< 16;
        tnbm_pkg::S_U4: begin
          p_r <= (64'(w_rd_r) + 64'(s2)) <<< 16;
          flag_r <= f2;
          delta_mem[idx] <= s2;
          delta_vld_r[idx] <= 1'b1;
        end
        tnbm_pkg::S_EMIT: begin
          case (item_r.opcode)
            tnbm_pkg::OP_LOAD: begin
              weight_mem[idx] <= item_r.value_a;
              delta_vld_r[idx] <= 1'b0;
            end
            tnbm_pkg::OP_READ: begin
              od_r <= '{kind: tnbm_pkg::K_READ, value: w_rd_r, saturated: 1'b0};
              ov_r <= 1'b1;
            end
            tnbm_pkg::OP_UPD: begin
              weight_mem[idx] <= s2;
              od_r <= '{kind: tnbm_pkg::K_UPD, value: s2, saturated: flag_r | f2};
              ov_r <= 1'b1;
            end
            default: begin
              grad_r <= s2;
              od_r <= '{kind: tnbm_pkg::K_GRAD, value: s2, saturated: flag_r | f2};
              ov_r <= 1'b1;
            end
          endcase
        end
        default: ;
      endcase
    end
  end

  // memory reads, registered
  always_ff @(posedge clk) begin
    w_rd_r <= weight_mem[idx];
    x_rd_r <= input_mem[idx];
    d_rd_r <= delta_vld_r[idx] ? delta_mem[idx] : 24'sd0;
  end

  a_out_one: assert property (@(posedge clk) disable iff (!rst_n)
    ov_r |=> !ov_r) else $error("result strobe longer than one cycle");
  a_cfg_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_ready |-> state_r == tnbm_pkg::S_IDLE) else $error("cfg ready while busy");
  a_acc_clr: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == tnbm_pkg::S_TANH_B) |=> acc_r == '0) else $error("acc not cleared");

endmodule
